@@ sv/cfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared constants for the centered FIR convolution block.
// ----------------------------------------------------------------------------
package cfc_pkg;

    localparam int MAX_HALF_DEF    = 15;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int TAP_W     = 16;
    localparam int TAP_IDX_W = 5;
    localparam int HALF_W    = 4;
    localparam int SHIFT_W   = 5;
    localparam int SEEN_W    = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SHIFT = 1'b1;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd15;
    localparam logic [SEEN_W-1:0]  SEEN_MAX    = 5'd31;

endpackage

@@ sv/centered_fir_convolution_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// centered_fir_convolution_top
// Odd-length centered FIR with zero padding, one result per sample.
// ----------------------------------------------------------------------------
// Taps and the sample delay line sit in two RAMs; the delay line is a
// circular buffer whose valid depth is tracked by a fill count, so there is
// no clearing pass after reset or at the end of a sequence. For a sample
// word that yields a result (H = half_width), one shared multiply-accumulate
// walks the 2*H+1 taps, one RAM read per cycle, followed by pipeline drain
// and a rounding and saturation step that waits for a free output register.
// A last sample adds the pending flush results, each run through the same
// multiply-accumulate pass. Input is accepted only while idle; a finished
// result waits in the output register while the next word enters. Register
// writes are taken only while idle and win over a waiting input word.
// ----------------------------------------------------------------------------
module centered_fir_convolution_top #(
    parameter int MAX_HALF    = cfc_pkg::MAX_HALF_DEF,
    parameter int SAMPLE_BITS = cfc_pkg::SAMPLE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,

    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [cfc_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [cfc_pkg::CFG_DAT_W-1:0]            i_cfg_data,

    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tap_index, coefficient, sample, zero fill
    input  logic [((21 + SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // op
    input  logic                                     s_axis_tuser,
    // last_sample
    input  logic                                     s_axis_tlast,

    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // result, zero fill
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // saturated
    output logic                                     m_axis_tuser,
    // last_result
    output logic                                     m_axis_tlast
);

    localparam int DEPTH    = 2 * MAX_HALF + 1;
    localparam int AW       = $clog2(DEPTH + 1);
    localparam int OUT_DW   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int PROD_W   = cfc_pkg::TAP_W + SAMPLE_BITS;
    localparam int ACC_RAW  = PROD_W + AW + 1;
    localparam int ACC_W    = (ACC_RAW > 33) ? ACC_RAW : 33;
    localparam int SMP_LSB  = cfc_pkg::TAP_IDX_W + cfc_pkg::TAP_W;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DONE,
        S_PUSH
    } t_state;

    t_state r_state;

    logic [cfc_pkg::HALF_W-1:0]  r_half;
    logic [cfc_pkg::SHIFT_W-1:0] r_shift;
    logic [cfc_pkg::SEEN_W-1:0]  r_seen;
    logic [AW-1:0]               r_fill;
    logic [AW-1:0]               r_wp;
    logic [AW-1:0]               r_pend;
    logic                        r_seq_last;
    logic                        r_emit_last;

    logic                        r_iss;
    logic [AW-1:0]               r_j;
    logic [AW-1:0]               r_ra;
    logic                        r_v1;
    logic                        r_z1;
    logic                        r_v2;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [ACC_W-1:0]     r_acc;

    logic                        r_out_valid;
    logic [SAMPLE_BITS-1:0]      r_out_data;
    logic                        r_out_sat;
    logic                        r_out_last;

    logic                        w_accept;
    logic                        w_is_load;
    logic [cfc_pkg::TAP_IDX_W-1:0] w_tap_idx;
    logic signed [cfc_pkg::TAP_W-1:0] w_coef;
    logic [SAMPLE_BITS-1:0]      w_sample;
    logic [AW-1:0]               w_h;
    logic [AW-1:0]               w_last_j;
    logic                        w_emit;
    logic [AW-1:0]               w_pend;
    logic [AW-1:0]               n_wp;
    logic [AW-1:0]               n_fill;
    logic [cfc_pkg::SEEN_W-1:0]  n_seen;
    logic [AW-1:0]               w_ra_dec;
    logic                        w_tap_we;
    logic                        w_dl_we;
    logic [cfc_pkg::TAP_W-1:0]   w_tap_rdata;
    logic [SAMPLE_BITS-1:0]      w_dl_rdata;
    logic signed [SAMPLE_BITS-1:0] w_mul_smp;
    logic signed [ACC_W-1:0]     w_rnd;
    logic signed [ACC_W-1:0]     w_shifted;
    logic                        w_sat_hi;
    logic                        w_sat_lo;
    logic                        w_out_free;

    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign w_is_load = (s_axis_tuser == cfc_pkg::OP_LOAD);
    assign w_tap_idx = s_axis_tdata[cfc_pkg::TAP_IDX_W-1:0];
    assign w_coef    = s_axis_tdata[cfc_pkg::TAP_IDX_W +: cfc_pkg::TAP_W];
    assign w_sample  = s_axis_tdata[SMP_LSB +: SAMPLE_BITS];

    always_comb begin
        if (32'(r_half) > MAX_HALF) begin
            w_h = AW'(MAX_HALF);
        end else begin
            w_h = AW'(r_half);
        end
    end

    assign w_last_j = AW'({w_h, 1'b0});
    assign w_emit   = (32'(r_seen) >= 32'(w_h));
    assign w_pend   = w_emit ? w_h : AW'(r_seen + 1'b1);
    assign n_wp     = (32'(r_wp) == DEPTH - 1) ? '0 : r_wp + 1'b1;
    assign n_fill   = (32'(r_fill) == DEPTH) ? r_fill : r_fill + 1'b1;
    assign n_seen   = (r_seen == cfc_pkg::SEEN_MAX) ? r_seen : r_seen + 1'b1;
    assign w_ra_dec = (r_ra == '0) ? AW'(DEPTH - 1) : r_ra - 1'b1;

    assign w_tap_we = w_accept && w_is_load && (32'(w_tap_idx) < DEPTH);
    assign w_dl_we  = (w_accept && !w_is_load) || (r_state == S_PUSH);

    cfc_ram #(
        .WIDTH  (cfc_pkg::TAP_W),
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (w_tap_we),
        .i_waddr (AW'(w_tap_idx)),
        .i_wdata (w_coef),
        .i_raddr (r_j),
        .o_rdata (w_tap_rdata)
    );

    cfc_ram #(
        .WIDTH  (SAMPLE_BITS),
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_dl_ram (
        .i_clk   (i_clk),
        .i_we    (w_dl_we),
        .i_waddr (r_wp),
        .i_wdata ((r_state == S_PUSH) ? '0 : w_sample),
        .i_raddr (r_ra),
        .o_rdata (w_dl_rdata)
    );

    assign w_mul_smp = r_z1 ? '0 : w_dl_rdata;

    // round half up, then floor shift
    assign w_rnd     = (r_shift == '0) ? '0 :
                       (ACC_W'(1) << (r_shift - 1'b1));
    assign w_shifted = (r_acc + w_rnd) >>> r_shift;
    assign w_sat_hi  = (w_shifted > SAT_HI);
    assign w_sat_lo  = (w_shifted < SAT_LO);
    assign w_out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_half      <= '0;
            r_shift     <= cfc_pkg::SHIFT_RESET;
            r_seen      <= '0;
            r_fill      <= '0;
            r_wp        <= '0;
            r_pend      <= '0;
            r_seq_last  <= 1'b0;
            r_emit_last <= 1'b0;
            r_iss       <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    cfc_pkg::REG_HALF_WIDTH: begin
                        r_half <= i_cfg_data[cfc_pkg::HALF_W-1:0];
                    end
                    cfc_pkg::REG_OUTPUT_SHIFT: begin
                        r_shift <= i_cfg_data[cfc_pkg::SHIFT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (m_axis_tvalid && m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            // MAC pipeline: read, multiply, accumulate
            r_v1 <= r_iss;
            r_v2 <= r_v1;
            if (r_v1) begin
                r_prod <= signed'(w_tap_rdata) * w_mul_smp;
            end
            if (r_v2) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            if (r_iss) begin
                r_z1 <= (r_j >= r_fill);
                r_j  <= r_j + 1'b1;
                r_ra <= w_ra_dec;
                if (r_j == w_last_j) begin
                    r_iss <= 1'b0;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && !w_is_load) begin
                        r_wp       <= n_wp;
                        r_fill     <= n_fill;
                        r_seen     <= n_seen;
                        r_seq_last <= s_axis_tlast;
                        r_pend     <= s_axis_tlast ? w_pend : '0;
                        if (w_emit) begin
                            r_emit_last <= s_axis_tlast && (w_h == '0);
                            r_acc       <= '0;
                            r_j         <= '0;
                            r_ra        <= r_wp;
                            r_iss       <= 1'b1;
                            r_state     <= S_MAC;
                        end else if (s_axis_tlast) begin
                            r_state <= S_PUSH;
                        end
                    end
                end
                S_MAC: begin
                    if (!r_iss && !r_v1 && !r_v2) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_last  <= r_emit_last;
                        r_out_sat   <= w_sat_hi || w_sat_lo;
                        if (w_sat_hi) begin
                            r_out_data <= SAT_HI[SAMPLE_BITS-1:0];
                        end else if (w_sat_lo) begin
                            r_out_data <= SAT_LO[SAMPLE_BITS-1:0];
                        end else begin
                            r_out_data <= w_shifted[SAMPLE_BITS-1:0];
                        end
                        if (r_pend != '0) begin
                            r_state <= S_PUSH;
                        end else begin
                            if (r_seq_last) begin
                                r_fill     <= '0;
                                r_seen     <= '0;
                                r_seq_last <= 1'b0;
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_PUSH: begin
                    // zero pad beyond the end of the sequence
                    r_wp        <= n_wp;
                    r_fill      <= n_fill;
                    r_pend      <= r_pend - 1'b1;
                    r_emit_last <= (r_pend == AW'(1));
                    r_acc       <= '0;
                    r_j         <= '0;
                    r_ra        <= r_wp;
                    r_iss       <= 1'b1;
                    r_state     <= S_MAC;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready   = i_rst_n && (r_state == S_IDLE);
    assign s_axis_tready = i_rst_n && (r_state == S_IDLE) && !i_cfg_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DW'(r_out_data);
    assign m_axis_tuser  = r_out_sat;
    assign m_axis_tlast  = r_out_last;

endmodule

@@ sv/cfc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfc_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module cfc_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 31,
    parameter int ADDR_W = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
